/* hw/rtl/fjd_pkg.sv */
package fjd_pkg;

   // Fixed field widths
   localparam int MASK_W  = 20;
   localparam int ID_W    = 5;
   localparam int PORT_W  = 5;
   localparam int KIND_W  = 2;
   localparam int REQ_DW  = 24;
   localparam int RSP_DW  = 24;

   // Item kinds carried in req_tuser
   localparam logic [KIND_W-1:0] KIND_CONTEXT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CFG_DONE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RESPONSE = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } fjd_state_type;

   typedef struct packed {
      logic capture;   // latch the incoming request
      logic execute;   // apply the latched request, load the result register
   } fjd_cmd_type;

   typedef struct packed {
      logic out_free;  // result register empty or being drained this cycle
   } fjd_status_type;

endpackage

/* hw/rtl/fanout_join_distributor.sv */
// An accepted request is latched; the controller then applies it and loads the result register on rsp_.
// The block takes one request at a time; the controller holds off the next one while the
//   latched request is applied and the result register is loaded.
// A result held back by rsp_tready stalls the apply step, not the result already waiting.
// Reset (synchronous, active high) clears all port flags, the armed flag, distributor_id
//   and the result valid; the block takes requests in the first cycle after reset.
module fanout_join_distributor
   import fjd_pkg::*;
#(
   parameter int ARITH_ENGINES = 8,  // arithmetic engines, two ports each
   parameter int LOAD_ENGINES  = 4   // loader engines, lowest physical ids
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   // tdata, low to high: is_arith[0], is_store[1], src_a[6:2], src_b[11:7],
   //   target_pe[16:12], resp_port[21:17], zero pad[23:22]
   input  logic [REQ_DW-1:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [KIND_W-1:0] req_tuser,
   // tlast: is_last
   input  logic              req_tlast,
   // result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tdata, low to high: forward_mask[19:0], respond_up[20], self_start[21], zero pad[23:22]
   output logic [RSP_DW-1:0] rsp_tdata,
   // distributor_id register
   input  logic              csr_we,
   input  logic [ID_W-1:0]   csr_wdata
);

   // Controller and datapath talk only through these two bundles.
   fjd_cmd_type    cmd;
   fjd_status_type status;

   // Sequencer: IDLE takes a request, EXEC applies it once the result slot frees up.
   fjd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Port flags, join counts and the result register live here.
   fjd_datapath #(
      .ARITH_ENGINES (ARITH_ENGINES),
      .LOAD_ENGINES  (LOAD_ENGINES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hw/rtl/fjd_ctrl.sv */
module fjd_ctrl
   import fjd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  fjd_status_type status,
   output fjd_cmd_type    cmd
);

   fjd_state_type state_ff;
   fjd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC: begin
            cmd.execute = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

/* hw/rtl/fjd_datapath.sv */
module fjd_datapath
   import fjd_pkg::*;
#(
   parameter int ARITH_ENGINES = 8,
   parameter int LOAD_ENGINES  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  fjd_cmd_type       cmd,
   output fjd_status_type    status,
   input  logic [REQ_DW-1:0] req_tdata,
   input  logic [KIND_W-1:0] req_tuser,
   input  logic              req_tlast,
   input  logic              csr_we,
   input  logic [ID_W-1:0]   csr_wdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata
);

   localparam int PORT_TOTAL = 2 * ARITH_ENGINES + LOAD_ENGINES;
   localparam int PORT_LIMIT = (PORT_TOTAL < MASK_W) ? PORT_TOTAL : MASK_W;

   // latched request fields
   logic [KIND_W-1:0] kind_ff;
   logic              is_arith_ff;
   logic              is_store_ff;
   logic [ID_W-1:0]   src_a_ff;
   logic [ID_W-1:0]   src_b_ff;
   logic [ID_W-1:0]   target_ff;
   logic              is_last_ff;
   logic [PORT_W-1:0] resp_port_ff;

   // tracker state
   logic [ID_W-1:0]   dist_id_ff;
   logic [MASK_W-1:0] selected_ff, selected_in;
   logic [MASK_W-1:0] sent_ff,     sent_in;
   logic [MASK_W-1:0] received_ff, received_in;
   logic              armed_ff,    armed_in;

   // result register
   logic              out_valid_ff;
   logic [MASK_W-1:0] fwd_ff,  fwd_in;
   logic              up_ff,   up_in;
   logic              self_ff, self_in;

   // context decode
   logic              rel_ok;
   logic [ID_W-1:0]   rel;
   logic [5:0]        sel_port;
   logic              sel_cand;
   logic              self_cand;
   logic              sel_hit;
   logic [MASK_W-1:0] sel_bit;

   // response decode
   logic              resp_ok;
   logic [MASK_W-1:0] recv_new;
   logic [PORT_W-1:0] n_sent;
   logic [PORT_W-1:0] n_recv;
   logic              join_done;

   assign status.out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff      <= req_tuser;
         is_arith_ff  <= req_tdata[0];
         is_store_ff  <= req_tdata[1];
         src_a_ff     <= req_tdata[6:2];
         src_b_ff     <= req_tdata[11:7];
         target_ff    <= req_tdata[16:12];
         resp_port_ff <= req_tdata[21:17];
         is_last_ff   <= req_tlast;
      end
   end

   always_comb begin
      rel_ok    = target_ff >= ID_W'(LOAD_ENGINES);
      rel       = target_ff - ID_W'(LOAD_ENGINES);
      sel_port  = '0;
      sel_cand  = 1'b0;
      self_cand = 1'b0;
      if (is_arith_ff) begin
         if (src_a_ff == dist_id_ff) begin
            sel_port  = {rel, 1'b0};
            sel_cand  = 1'b1;
            self_cand = src_a_ff == target_ff;
         end else if (src_b_ff == dist_id_ff) begin
            sel_port  = {rel, 1'b1};
            sel_cand  = 1'b1;
            self_cand = src_b_ff == target_ff;
         end
      end else if (is_store_ff) begin
         if (src_a_ff == dist_id_ff) begin
            sel_port = {1'b0, rel} + 6'(ARITH_ENGINES);
            sel_cand = 1'b1;
         end
      end
      sel_hit = sel_cand && rel_ok && (int'(sel_port) < PORT_LIMIT);
      sel_bit = MASK_W'(1) << sel_port;
   end

   always_comb begin
      resp_ok   = int'(resp_port_ff) < PORT_LIMIT;
      recv_new  = received_ff | (resp_ok ? (MASK_W'(1) << resp_port_ff) : '0);
      n_sent    = PORT_W'($countones(selected_ff & sent_ff));
      n_recv    = PORT_W'($countones(selected_ff & recv_new));
      join_done = (n_sent == n_recv) && (n_sent != '0);
   end

   always_comb begin
      selected_in = selected_ff;
      sent_in     = sent_ff;
      received_in = received_ff;
      armed_in    = armed_ff;
      fwd_in      = '0;
      up_in       = 1'b0;
      self_in     = 1'b0;
      case (kind_ff)
         KIND_CONTEXT: begin
            if (sel_hit) begin
               selected_in = selected_ff | sel_bit;
               sent_in     = sent_ff & ~sel_bit;
               received_in = received_ff & ~sel_bit;
               self_in     = self_cand;
            end
         end
         KIND_CFG_DONE: begin
            armed_in = 1'b1;
         end
         KIND_REQUEST: begin
            if (is_last_ff) begin
               armed_in = 1'b0;
            end
            fwd_in  = selected_ff;
            sent_in = sent_ff | selected_ff;
         end
         KIND_RESPONSE: begin
            received_in = recv_new;
            if (join_done) begin
               if (!armed_ff) begin
                  selected_in = '0;
               end
               sent_in     = '0;
               received_in = '0;
               up_in       = 1'b1;
            end
         end
         default: begin
            armed_in = armed_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_id_ff   <= '0;
         selected_ff  <= '0;
         sent_ff      <= '0;
         received_ff  <= '0;
         armed_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            dist_id_ff <= csr_wdata;
         end
         if (cmd.execute) begin
            selected_ff  <= selected_in;
            sent_ff      <= sent_in;
            received_ff  <= received_in;
            armed_ff     <= armed_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         fwd_ff  <= fwd_in;
         up_ff   <= up_in;
         self_ff <= self_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, self_ff, up_ff, fwd_ff};

endmodule

/* hw/rtl/fjd_checker.sv */
module fjd_checker
   import fjd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata
);

   // a stalled result stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // one request at a time: busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous still in work");

   // result flags come from different request kinds and never mix
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[20] && rsp_tdata[21])
                  && !(rsp_tdata[20] && (rsp_tdata[19:0] != '0))
                  && !(rsp_tdata[21] && (rsp_tdata[19:0] != '0)))
      else $error("result mixes forward, join and self-start");

   // nothing pending out of reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind fanout_join_distributor fjd_checker u_fjd_checker (.*);

/* tb/sv/fjd_join_monitor.sv */
module fjd_join_monitor
   import fjd_pkg::*;
#(
   parameter int ARITH_ENGINES = 8,
   parameter int LOAD_ENGINES  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   // tdata, low to high: is_arith, is_store, src_a, src_b, target_pe, resp_port, pad
   input  logic [REQ_DW-1:0] req_tdata,
   // tuser: req_type
   input  logic [KIND_W-1:0] req_tuser,
   input  logic              req_tlast,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   // tdata, low to high: forward_mask, respond_up, self_start, pad
   input  logic [RSP_DW-1:0] rsp_tdata,
   input  logic              csr_we,
   input  logic [ID_W-1:0]   csr_wdata,
   output int unsigned       outstanding,
   output int unsigned       fault_count
);

   localparam int PORT_TOTAL = 2 * ARITH_ENGINES + LOAD_ENGINES;
   localparam int PORT_LIMIT = (PORT_TOTAL < MASK_W) ? PORT_TOTAL : MASK_W;

   typedef struct packed {
      logic              self_start;
      logic              respond_up;
      logic [MASK_W-1:0] forward_mask;
   } join_result_type;

   join_result_type   pending_results[$];
   logic [ID_W-1:0]   dist_id;
   logic [MASK_W-1:0] sel_ports;
   logic [MASK_W-1:0] sent_ports;
   logic [MASK_W-1:0] rcvd_ports;
   logic              armed;
   int unsigned       faults = 0;

   // selecting a port restarts its join bookkeeping
   function automatic bit claim_port(int port);
      logic [PORT_W-1:0] bit_idx;
      if (port < 0 || port >= PORT_LIMIT) return 1'b0;
      bit_idx             = PORT_W'(port);
      sel_ports[bit_idx]  = 1'b1;
      sent_ports[bit_idx] = 1'b0;
      rcvd_ports[bit_idx] = 1'b0;
      return 1'b1;
   endfunction

   function automatic join_result_type predict_join_result(logic [KIND_W-1:0] kind,
                                                           logic [REQ_DW-1:0] data,
                                                           logic last);
      logic             is_arith;
      logic             is_store;
      logic [ID_W-1:0]  src_a;
      logic [ID_W-1:0]  src_b;
      logic [ID_W-1:0]  target;
      logic [PORT_W-1:0] rport;
      int               rel;
      join_result_type  res;
      is_arith = data[0];
      is_store = data[1];
      src_a    = data[6:2];
      src_b    = data[11:7];
      target   = data[16:12];
      rport    = data[21:17];
      rel      = int'(target) - LOAD_ENGINES;
      res      = '0;
      case (kind)
         KIND_CONTEXT: begin
            if (is_arith) begin
               if (src_a == dist_id) begin
                  if (rel >= 0 && claim_port(2 * rel) && src_a == target)
                     res.self_start = 1'b1;
               end else if (src_b == dist_id) begin
                  if (rel >= 0 && claim_port(2 * rel + 1) && src_b == target)
                     res.self_start = 1'b1;
               end
            end else if (is_store) begin
               if (src_a == dist_id && rel >= 0) void'(claim_port(rel + ARITH_ENGINES));
            end
         end
         KIND_CFG_DONE: armed = 1'b1;
         KIND_REQUEST: begin
            if (last) armed = 1'b0;
            res.forward_mask = sel_ports;
            sent_ports |= sel_ports;
         end
         KIND_RESPONSE: begin
            if (int'(rport) < PORT_LIMIT) rcvd_ports[rport] = 1'b1;
            if ($countones(sel_ports & sent_ports) == $countones(sel_ports & rcvd_ports) &&
                (sel_ports & sent_ports) != '0) begin
               if (!armed) sel_ports = '0;
               sent_ports     = '0;
               rcvd_ports     = '0;
               res.respond_up = 1'b1;
            end
         end
         default: armed = armed;
      endcase
      return res;
   endfunction

   function automatic void check_field(string name, logic [MASK_W-1:0] want,
                                       logic [MASK_W-1:0] got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         faults++;
      end
   endfunction

   always @(posedge clock) begin
      join_result_type got;
      join_result_type want;
      if (reset) begin
         pending_results.delete();
         dist_id    = '0;
         sel_ports  = '0;
         sent_ports = '0;
         rcvd_ports = '0;
         armed      = 1'b0;
      end else begin
         // results first: none can stem from a request taken at this same edge
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[MASK_W+1:0];
            if (pending_results.size() == 0) begin
               $error("unexpected result: tdata 0x%0h", rsp_tdata);
               faults++;
            end else begin
               want = pending_results.pop_front();
               check_field("forward_mask", want.forward_mask, got.forward_mask);
               check_field("respond_up", MASK_W'(want.respond_up), MASK_W'(got.respond_up));
               check_field("self_start", MASK_W'(want.self_start), MASK_W'(got.self_start));
            end
         end
         if (csr_we) dist_id = csr_wdata;
         if (req_tvalid && req_tready)
            pending_results.push_back(predict_join_result(req_tuser, req_tdata, req_tlast));
      end
      outstanding <= pending_results.size();
      fault_count <= faults;
   end

endmodule

/* tb/sv/tb_fanout_join_distributor.sv */
module tb_fanout_join_distributor;
   import fjd_pkg::*;

   localparam int ARITH_ENGINES  = 8;
   localparam int LOAD_ENGINES   = 4;
   // highest targets that still map to a port below twenty
   localparam int ARITH_T_MAX    = LOAD_ENGINES + 9;
   localparam int STORE_T_MAX    = LOAD_ENGINES + MASK_W - 1 - ARITH_ENGINES;
   localparam int PHASE_ITEMS    = 290;
   localparam int WATCHDOG_LIMIT = 2000;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;
   logic [KIND_W-1:0] req_tuser  = KIND_CONTEXT;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_we     = 1'b0;
   logic [ID_W-1:0]   csr_wdata  = '0;
   int unsigned       outstanding;
   int unsigned       fault_count;

   bit                calm        = 1'b0;  // final stretch: no idling on either side
   bit                tx_gaps     = 1'b1;  // sender may idle inside the current sequence
   int unsigned       sent_items  = 0;
   int unsigned       idle_cycles = 0;
   int unsigned       stall_left  = 0;
   int unsigned       quiet_left  = 0;
   logic [ID_W-1:0]   cur_id      = '0;
   int                port_plan[$];       // ports the current sequence expects to hear from

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fanout_join_distributor #(
      .ARITH_ENGINES(ARITH_ENGINES),
      .LOAD_ENGINES (LOAD_ENGINES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   fjd_join_monitor #(
      .ARITH_ENGINES(ARITH_ENGINES),
      .LOAD_ENGINES (LOAD_ENGINES)
   ) u_join_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .outstanding(outstanding),
      .fault_count(fault_count)
   );

   // Result side backpressure: random stall bursts, plus quiet
   // stretches of steady ready so gaps land on every phase of the block.
   always @(posedge clock) begin
      if (calm || reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (quiet_left != 0) begin
         quiet_left <= quiet_left - 1;
         rsp_tready <= 1'b1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1: begin
               stall_left <= $urandom_range(0, 8);
               rsp_tready <= 1'b0;
            end
            2: begin
               quiet_left <= $urandom_range(10, 40);
               rsp_tready <= 1'b1;
            end
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // Watchdog: cycles without any request, result or register write.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [REQ_DW-1:0] pack_req(logic arith, logic store,
                                                  logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                                                  logic [ID_W-1:0] t, logic [PORT_W-1:0] p);
      return {2'b00, p, t, b, a, store, arith};
   endfunction

   // Present one request and hold it until taken. Valid stays high into the
   // next request unless a gap is drawn.
   task automatic send_item(logic [KIND_W-1:0] kind, logic [REQ_DW-1:0] data, logic last);
      if (!calm && tx_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
   endtask

   // context write; resp_port and tlast carry junk the block must ignore
   task automatic send_ctx(logic arith, logic store, logic [ID_W-1:0] a,
                           logic [ID_W-1:0] b, logic [ID_W-1:0] t);
      send_item(KIND_CONTEXT, pack_req(arith, store, a, b, t, PORT_W'($urandom_range(0, 31))),
                1'($urandom_range(0, 1)));
   endtask

   task automatic send_rq(logic last);
      send_item(KIND_REQUEST, REQ_DW'($urandom & 32'h3F_FFFF), last);
   endtask

   task automatic send_resp(logic [PORT_W-1:0] port);
      send_item(KIND_RESPONSE,
                pack_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         ID_W'($urandom_range(0, 31)), ID_W'($urandom_range(0, 31)),
                         ID_W'($urandom_range(0, 31)), port),
                1'($urandom_range(0, 1)));
   endtask

   task automatic send_noise();
      send_item(KIND_W'($urandom_range(0, 3)), REQ_DW'($urandom & 32'h3F_FFFF),
                1'($urandom_range(0, 1)));
   endtask

   // Let every pending result drain, then a few spare cycles. The first edge
   // lets the monitor's count catch up with the last request.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_dist_id(logic [ID_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      cur_id     = value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One well-formed join: contexts that select ports of this distributor,
   // maybe a config-done, one or two requests, then responses in random
   // order with the odd port dropped or a stray one added.
   task automatic run_transaction();
      bit              arith;
      bit              use_b;
      logic [ID_W-1:0] a;
      logic [ID_W-1:0] b;
      logic [ID_W-1:0] t;
      int              port;
      int              idx;
      tx_gaps = ($urandom_range(0, 2) != 0);
      port_plan.delete();
      repeat ($urandom_range(1, 4)) begin
         arith = ($urandom_range(0, 3) != 0);
         t = arith ? ID_W'($urandom_range(LOAD_ENGINES, ARITH_T_MAX))
                   : ID_W'($urandom_range(LOAD_ENGINES, STORE_T_MAX));
         // engine feeding itself -> self-start
         if (arith && cur_id >= LOAD_ENGINES && cur_id <= ARITH_T_MAX &&
             $urandom_range(0, 3) == 0)
            t = cur_id;
         use_b = 1'($urandom_range(0, 1));
         a = ID_W'($urandom_range(0, 31));
         b = ID_W'($urandom_range(0, 31));
         if (arith && use_b) begin
            b = cur_id;
            if (a == cur_id) a = a + 5'd1;
            port = 2 * (int'(t) - LOAD_ENGINES) + 1;
         end else if (arith) begin
            a = cur_id;
            port = 2 * (int'(t) - LOAD_ENGINES);
         end else begin
            a = cur_id;
            port = int'(t) - LOAD_ENGINES + ARITH_ENGINES;
         end
         // store flag on an arith context must not change the outcome
         send_ctx(arith, arith ? logic'($urandom_range(0, 1)) : 1'b1, a, b, t);
         port_plan.push_back(port);
      end
      if ($urandom_range(0, 2) == 0)
         send_item(KIND_CFG_DONE, REQ_DW'($urandom & 32'h3F_FFFF), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 2)) send_rq($urandom_range(0, 3) == 0);
      while (port_plan.size() != 0) begin
         idx = $urandom_range(0, port_plan.size() - 1);
         if ($urandom_range(0, 9) != 0) send_resp(PORT_W'(port_plan[idx]));
         port_plan.delete(idx);
         if ($urandom_range(0, 14) == 0) send_resp(PORT_W'($urandom_range(0, 31)));
      end
   endtask

   initial begin
      int unsigned stop_at;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, distributor id 6 ----
      write_dist_id(5'd6);
      send_ctx(1'b1, 1'b0, cur_id, 5'd0, 5'd6);     // A matches, feeds itself: port 4 + self
      send_ctx(1'b1, 1'b0, 5'd1, cur_id, 5'd6);     // B matches, self via B: port 5 + self
      send_ctx(1'b1, 1'b0, cur_id, cur_id, 5'd7);   // both match: A port only (6)
      send_ctx(1'b1, 1'b1, cur_id, 5'd2, 5'd8);     // arith and store both set: arith (8)
      send_ctx(1'b0, 1'b1, cur_id, 5'd0, 5'd15);    // store, top port 19
      send_ctx(1'b0, 1'b1, 5'd3, cur_id, 5'd5);     // store only compares A: nothing
      send_ctx(1'b0, 1'b0, cur_id, cur_id, 5'd6);   // neither kind: nothing
      send_ctx(1'b1, 1'b0, cur_id, 5'd0, 5'd3);     // target is a loader: ignored
      send_ctx(1'b1, 1'b0, cur_id, 5'd0, 5'd31);    // port far out of range: no self-start
      send_ctx(1'b0, 1'b1, cur_id, 5'd0, 5'd16);    // store port 20: ignored
      send_rq(1'b0);                                // fans out to 4,5,6,8,19
      send_resp(5'd31);                             // out-of-range response, join still runs
      send_resp(5'd4);
      send_resp(5'd5);
      send_resp(5'd6);
      send_resp(5'd8);
      send_resp(5'd19);                             // join completes, not armed: cleared
      send_rq(1'b1);                                // nothing selected, last still disarms
      send_item(KIND_CFG_DONE, '0, 1'b0);           // arm
      send_ctx(1'b1, 1'b0, cur_id, 5'd0, 5'd11);    // port 14
      send_rq(1'b0);
      send_resp(5'd14);                             // join, armed: selection kept
      send_rq(1'b1);                                // still forwards to 14, then disarms
      send_resp(5'd14);                             // join, selection cleared
      send_resp(5'd0);                              // nothing sent: no join

      // ---- random part: extremes of the id first, then random ids ----
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 4) calm = 1'b1;
         write_dist_id(phase == 0 ? 5'd0 : phase == 1 ? 5'd31 : 5'($urandom_range(0, 31)));
         stop_at = sent_items + PHASE_ITEMS;
         while (sent_items < stop_at) begin
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 4)) send_noise();
            else
               run_transaction();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
